FILE: src/mcpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults of the multi-channel priority deque.
package mcpd_pkg;

  // Default sizes handed to the top level parameters
  localparam int NUM_CHANNELS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 8;

  // Fixed field widths of the request and result ports
  localparam int CH_PORT_W = 5;
  localparam int ID_W      = 16;
  localparam int PRI_W     = 2;
  localparam int OCC_W     = 4;
  localparam int LIMIT_W   = 4;
  localparam int STATUS_W  = 3;

  // Queue limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

  // Priority codes of an add
  localparam logic [PRI_W-1:0] PRI_REGULAR = 2'd0;
  localparam logic [PRI_W-1:0] PRI_URGENT  = 2'd1;

  // Request kind
  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_TAKE = 1'b1
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_INVALID = 3'd2,
    ST_SERVED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EVAL  = 2'd1,
    S_FETCH = 2'd2
  } state_e;

endpackage

FILE: src/mcpd_ptr_table.sv
`timescale 1ns / 1ps
// Per-channel head pointer and entry count memory; unwritten channels read as empty.
module mcpd_ptr_table #(
  parameter int NUM_CHANNELS = mcpd_pkg::NUM_CHANNELS_DEF,
  parameter int QUEUE_DEPTH  = mcpd_pkg::QUEUE_DEPTH_DEF,
  localparam int CH_IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int HEAD_W      = $clog2(QUEUE_DEPTH),
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [CH_IDX_W-1:0] rd_addr_i,
  output logic [HEAD_W-1:0]   rd_head_o,
  output logic [CNT_W-1:0]    rd_cnt_o,
  input  logic                wr_en_i,
  input  logic [CH_IDX_W-1:0] wr_addr_i,
  input  logic [HEAD_W-1:0]   wr_head_i,
  input  logic [CNT_W-1:0]    wr_cnt_i
);

  logic [HEAD_W-1:0]       head_mem [NUM_CHANNELS];
  logic [CNT_W-1:0]        cnt_mem  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] written_q;
  logic [HEAD_W-1:0]       rd_head_q;
  logic [CNT_W-1:0]        rd_cnt_q;
  logic                    rd_written_q;

  // Written flags: cleared at reset, set on the first write of a channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  // Synchronous memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      head_mem[wr_addr_i] <= wr_head_i;
      cnt_mem[wr_addr_i]  <= wr_cnt_i;
    end
    if (rd_en_i) begin
      rd_head_q <= head_mem[rd_addr_i];
      rd_cnt_q  <= cnt_mem[rd_addr_i];
    end
  end

  // A channel never written holds head 0 and no entries
  assign rd_head_o = rd_written_q ? rd_head_q : '0;
  assign rd_cnt_o  = rd_written_q ? rd_cnt_q  : '0;

endmodule

FILE: src/multi_channel_priority_deque.sv
`timescale 1ns / 1ps
// Top level of the multi-channel two-priority bounded deque.
//
// One request is taken when start_i is high and busy_o low; each request
// gives exactly one result, shown for one cycle with done_o high, which the
// receiver cannot stall. An add, a rejected add or a take from an empty or
// unknown channel returns its result after the registered pointer table read
// and S_EVAL, and a new request may be taken in that same cycle; a take that
// serves an entry returns after the pointer table read, S_EVAL and the
// registered entry store read in S_FETCH, again freeing the block for a new
// request in the cycle of its result. Pointer state of all channels reads as
// empty right after reset through per-channel written flags; no clearing pass
// is run. queue_limit_i may be written whenever no request is in flight.
module multi_channel_priority_deque #(
  parameter int NUM_CHANNELS = mcpd_pkg::NUM_CHANNELS_DEF,
  parameter int QUEUE_DEPTH  = mcpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            queue_limit_we_i,
  input  logic [mcpd_pkg::LIMIT_W-1:0]    queue_limit_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            mode_i,
  input  logic [mcpd_pkg::CH_PORT_W-1:0]  channel_i,
  input  logic [mcpd_pkg::ID_W-1:0]       entry_id_i,
  input  logic [mcpd_pkg::PRI_W-1:0]      priority_req_i,
  output logic                            done_o,
  output logic [mcpd_pkg::STATUS_W-1:0]   status_o,
  output logic [mcpd_pkg::ID_W-1:0]       served_id_o,
  output logic [mcpd_pkg::OCC_W-1:0]      occupancy_o
);

  localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HEAD_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int ENTRIES   = NUM_CHANNELS * QUEUE_DEPTH;
  localparam int ENTRY_AW  = $clog2(ENTRIES);

  // Sequencer and request registers
  mcpd_pkg::state_e              state_q, state_d;
  logic [mcpd_pkg::LIMIT_W-1:0]  limit_q;
  logic                          mode_q;
  logic [CH_IDX_W-1:0]           chan_q;
  logic                          chan_ok_q;
  logic [mcpd_pkg::ID_W-1:0]     id_q;
  logic [mcpd_pkg::PRI_W-1:0]    pri_q;
  logic [CNT_W-1:0]              pend_cnt_q, pend_cnt_d;

  // Result registers
  logic                          done_q, done_d;
  mcpd_pkg::status_e             status_q, status_d;
  logic [mcpd_pkg::ID_W-1:0]     served_q, served_d;
  logic [mcpd_pkg::OCC_W-1:0]    occ_q, occ_d;

  // Pointer table access
  logic                          ptr_rd_en;
  logic [HEAD_W-1:0]             ptr_head;
  logic [CNT_W-1:0]              ptr_cnt;
  logic                          ptr_wr_en;
  logic [HEAD_W-1:0]             ptr_wr_head;
  logic [CNT_W-1:0]              ptr_wr_cnt;

  // Entry store access
  logic [mcpd_pkg::ID_W-1:0]     entry_mem [ENTRIES];
  logic [mcpd_pkg::ID_W-1:0]     entry_rd_q;
  logic                          entry_wr_en;
  logic                          entry_rd_en;
  logic [HEAD_W-1:0]             entry_pos;
  logic [ENTRY_AW-1:0]           entry_addr;

  // Ring arithmetic on the fetched pointer
  logic                          accept;
  logic                          chan_ok;
  logic [HEAD_W-1:0]             head_dec;
  logic [HEAD_W-1:0]             head_inc;
  logic [SUM_W-1:0]              tail_sum;
  logic [HEAD_W-1:0]             tail_pos;
  logic                          is_full;

  assign accept  = start_i && !busy_o;
  assign chan_ok = 32'(channel_i) < 32'(NUM_CHANNELS);

  assign head_dec = (ptr_head == '0) ? HEAD_W'(QUEUE_DEPTH - 1) : ptr_head - 1'b1;
  assign head_inc = (ptr_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_head + 1'b1;
  assign tail_sum = SUM_W'(ptr_head) + SUM_W'(ptr_cnt);
  assign tail_pos = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                    ? HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);
  // A limit above the ring depth acts as the depth
  assign is_full  = (8'(ptr_cnt) >= 8'(limit_q)) || (8'(ptr_cnt) >= 8'(QUEUE_DEPTH));

  assign entry_addr = ENTRY_AW'(chan_q) * ENTRY_AW'(QUEUE_DEPTH) + ENTRY_AW'(entry_pos);

  mcpd_ptr_table #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_ptr_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ptr_rd_en),
    .rd_addr_i (CH_IDX_W'(channel_i)),
    .rd_head_o (ptr_head),
    .rd_cnt_o  (ptr_cnt),
    .wr_en_i   (ptr_wr_en),
    .wr_addr_i (chan_q),
    .wr_head_i (ptr_wr_head),
    .wr_cnt_i  (ptr_wr_cnt)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcpd_pkg::S_IDLE;
      limit_q <= mcpd_pkg::LIMIT_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (queue_limit_we_i) begin
        limit_q <= queue_limit_i;
      end
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= mode_i;
      chan_q    <= CH_IDX_W'(channel_i);
      chan_ok_q <= chan_ok;
      id_q      <= entry_id_i;
      pri_q     <= priority_req_i;
    end
    pend_cnt_q <= pend_cnt_d;
    status_q   <= status_d;
    served_q   <= served_d;
    occ_q      <= occ_d;
  end

  // Entry store: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (entry_wr_en) begin
      entry_mem[entry_addr] <= id_q;
    end
    if (entry_rd_en) begin
      entry_rd_q <= entry_mem[entry_addr];
    end
  end

  // Sequencer: fetch pointer, evaluate and write back, fetch entry on a serving take
  always_comb begin
    state_d     = state_q;
    pend_cnt_d  = pend_cnt_q;
    done_d      = 1'b0;
    status_d    = status_q;
    served_d    = served_q;
    occ_d       = occ_q;
    ptr_rd_en   = 1'b0;
    ptr_wr_en   = 1'b0;
    ptr_wr_head = ptr_head;
    ptr_wr_cnt  = ptr_cnt;
    entry_wr_en = 1'b0;
    entry_rd_en = 1'b0;
    entry_pos   = ptr_head;
    case (state_q)
      mcpd_pkg::S_IDLE: begin
        if (accept) begin
          ptr_rd_en = 1'b1;
          state_d   = mcpd_pkg::S_EVAL;
        end
      end
      mcpd_pkg::S_EVAL: begin
        state_d  = mcpd_pkg::S_IDLE;
        served_d = '0;
        occ_d    = mcpd_pkg::OCC_W'(ptr_cnt);
        if (!chan_ok_q) begin
          // Unknown channel holds nothing
          done_d   = 1'b1;
          status_d = (mode_q == mcpd_pkg::MODE_TAKE) ? mcpd_pkg::ST_EMPTY : mcpd_pkg::ST_FULL;
          occ_d    = '0;
        end else if (mode_q == mcpd_pkg::MODE_ADD) begin
          done_d = 1'b1;
          if (is_full) begin
            status_d = mcpd_pkg::ST_FULL;
          end else if (pri_q == mcpd_pkg::PRI_URGENT) begin
            // Urgent add goes in front of the head
            status_d    = mcpd_pkg::ST_ADDED;
            entry_pos   = head_dec;
            entry_wr_en = 1'b1;
            ptr_wr_en   = 1'b1;
            ptr_wr_head = head_dec;
            ptr_wr_cnt  = ptr_cnt + 1'b1;
            occ_d       = mcpd_pkg::OCC_W'(ptr_wr_cnt);
          end else if (pri_q == mcpd_pkg::PRI_REGULAR) begin
            // Regular add goes behind the tail
            status_d    = mcpd_pkg::ST_ADDED;
            entry_pos   = tail_pos;
            entry_wr_en = 1'b1;
            ptr_wr_en   = 1'b1;
            ptr_wr_cnt  = ptr_cnt + 1'b1;
            occ_d       = mcpd_pkg::OCC_W'(ptr_wr_cnt);
          end else begin
            status_d = mcpd_pkg::ST_INVALID;
          end
        end else if (ptr_cnt == '0) begin
          done_d   = 1'b1;
          status_d = mcpd_pkg::ST_EMPTY;
        end else begin
          // Serve the head entry; result follows once the read returns
          entry_rd_en = 1'b1;
          ptr_wr_en   = 1'b1;
          ptr_wr_head = head_inc;
          ptr_wr_cnt  = ptr_cnt - 1'b1;
          pend_cnt_d  = ptr_wr_cnt;
          state_d     = mcpd_pkg::S_FETCH;
        end
      end
      mcpd_pkg::S_FETCH: begin
        done_d   = 1'b1;
        status_d = mcpd_pkg::ST_SERVED;
        served_d = entry_rd_q;
        occ_d    = mcpd_pkg::OCC_W'(pend_cnt_q);
        state_d  = mcpd_pkg::S_IDLE;
      end
      default: begin
        state_d = mcpd_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != mcpd_pkg::S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign served_id_o = served_q;
  assign occupancy_o = occ_q;

  // Results are never back to back
  a_done_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  // An accepted request always goes on to evaluation
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == mcpd_pkg::S_EVAL))
    else $error("accepted request did not reach evaluation");

  // A served result comes only from the entry fetch
  a_served_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == mcpd_pkg::ST_SERVED) |-> ($past(state_q) == mcpd_pkg::S_FETCH))
    else $error("served result without an entry fetch");

  // Only a served result carries an id
  a_served_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != mcpd_pkg::ST_SERVED) |-> (served_id_o == '0))
    else $error("nonzero id on a result that served nothing");

  // Store and pointer table never see a write and a fetch read together
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(entry_wr_en && entry_rd_en) && !(ptr_rd_en && ptr_wr_en))
    else $error("read and write of the same memory in one cycle");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the multi-channel two-priority bounded deque.
module testbench;

  // One request as driven on the request ports
  typedef struct packed {
    mcpd_pkg::mode_e                mode;
    logic [mcpd_pkg::CH_PORT_W-1:0] channel;
    logic [mcpd_pkg::ID_W-1:0]      entry_id;
    logic [mcpd_pkg::PRI_W-1:0]     prio;
  } deque_req_t;

  // One result as seen on the result ports
  typedef struct packed {
    mcpd_pkg::status_e          status;
    logic [mcpd_pkg::ID_W-1:0]  served_id;
    logic [mcpd_pkg::OCC_W-1:0] occupancy;
  } deque_result_t;

  localparam int NCH   = mcpd_pkg::NUM_CHANNELS_DEF;
  localparam int DEPTH = mcpd_pkg::QUEUE_DEPTH_DEF;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           queue_limit_we_i;
  logic [mcpd_pkg::LIMIT_W-1:0]   queue_limit_i;
  logic                           start_i;
  logic                           busy_o;
  logic                           mode_i;
  logic [mcpd_pkg::CH_PORT_W-1:0] channel_i;
  logic [mcpd_pkg::ID_W-1:0]      entry_id_i;
  logic [mcpd_pkg::PRI_W-1:0]     priority_req_i;
  logic                           done_o;
  logic [mcpd_pkg::STATUS_W-1:0]  status_o;
  logic [mcpd_pkg::ID_W-1:0]      served_id_o;
  logic [mcpd_pkg::OCC_W-1:0]     occupancy_o;

  // Shadow copy of the per-channel rings and the limit register
  logic [mcpd_pkg::ID_W-1:0]    shadow_ids [NCH][DEPTH];
  int unsigned                  front_slot [NCH] = '{default: 0};
  int unsigned                  held_count [NCH] = '{default: 0};
  logic [mcpd_pkg::LIMIT_W-1:0] limit_q = mcpd_pkg::LIMIT_RESET;

  deque_result_t pending_results [$];
  int            mismatch_count = 0;

  always #5 clk_i = ~clk_i;

  multi_channel_priority_deque i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .queue_limit_we_i (queue_limit_we_i),
    .queue_limit_i    (queue_limit_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .channel_i        (channel_i),
    .entry_id_i       (entry_id_i),
    .priority_req_i   (priority_req_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .served_id_o      (served_id_o),
    .occupancy_o      (occupancy_o)
  );

  // Apply one request to the shadow rings and return the result it gives
  function automatic deque_result_t serve_or_store(deque_req_t req);
    deque_result_t res;
    int unsigned   ch;
    int unsigned   cap;
    int unsigned   slot;
    ch            = req.channel;
    res.served_id = '0;
    if (req.mode == mcpd_pkg::MODE_ADD) begin
      cap = (limit_q > DEPTH) ? DEPTH : limit_q;
      if (held_count[ch] >= cap) begin
        // full wins over a bad priority
        res.status = mcpd_pkg::ST_FULL;
      end else if (req.prio != mcpd_pkg::PRI_REGULAR && req.prio != mcpd_pkg::PRI_URGENT) begin
        res.status = mcpd_pkg::ST_INVALID;
      end else begin
        if (req.prio == mcpd_pkg::PRI_URGENT) begin
          front_slot[ch] = (front_slot[ch] + DEPTH - 1) % DEPTH;
          slot           = front_slot[ch];
        end else begin
          slot = (front_slot[ch] + held_count[ch]) % DEPTH;
        end
        shadow_ids[ch][slot] = req.entry_id;
        held_count[ch]++;
        res.status = mcpd_pkg::ST_ADDED;
      end
    end else if (held_count[ch] == 0) begin
      res.status = mcpd_pkg::ST_EMPTY;
    end else begin
      res.served_id  = shadow_ids[ch][front_slot[ch]];
      front_slot[ch] = (front_slot[ch] + 1) % DEPTH;
      held_count[ch]--;
      res.status = mcpd_pkg::ST_SERVED;
    end
    res.occupancy = mcpd_pkg::OCC_W'(held_count[ch]);
    return res;
  endfunction

  function automatic deque_req_t make_req(mcpd_pkg::mode_e m, int ch, int id, int p);
    deque_req_t req;
    req.mode     = m;
    req.channel  = mcpd_pkg::CH_PORT_W'(ch);
    req.entry_id = mcpd_pkg::ID_W'(id);
    req.prio     = mcpd_pkg::PRI_W'(p);
    return req;
  endfunction

  // Result checker: every done transaction against the oldest prediction
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result status %0d id %h occupancy %0d",
                   $realtime, status_o, served_id_o, occupancy_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || served_id_o !== want.served_id ||
            occupancy_o !== want.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: expected status %0d id %h occupancy %0d, got %0d %h %0d",
                     $realtime, want.status, want.served_id, want.occupancy,
                     status_o, served_id_o, occupancy_o);
        end
      end
    end
  end

  // Drive one request and hold it until the block takes it
  task automatic send_request(input deque_req_t req);
    start_i        <= 1'b1;
    mode_i         <= req.mode;
    channel_i      <= req.channel;
    entry_id_i     <= req.entry_id;
    priority_req_i <= req.prio;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.push_back(serve_or_store(req));
  endtask

  task automatic add_entry(input int ch, input int id, input int p);
    send_request(make_req(mcpd_pkg::MODE_ADD, ch, id, p));
  endtask

  // id and priority are don't-care on a take, so they get noise
  task automatic take_entry(input int ch);
    send_request(make_req(mcpd_pkg::MODE_TAKE, ch, $urandom, $urandom));
  endtask

  // Sender pause, taken with the given chance in percent
  task automatic hold_off(input int pct);
    if ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Stop sending and let every outstanding transaction come back
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_queue_limit(input int value);
    settle();
    queue_limit_we_i <= 1'b1;
    queue_limit_i    <= mcpd_pkg::LIMIT_W'(value);
    @(posedge clk_i);
    limit_q = mcpd_pkg::LIMIT_W'(value);
    queue_limit_we_i <= 1'b0;
  endtask

  // Reset limit of five; full is reported ahead of a bad priority
  task automatic test_default_limit();
    take_entry(0);
    add_entry(0, 16'hFFFF, mcpd_pkg::PRI_REGULAR);
    add_entry(0, 16'h0000, mcpd_pkg::PRI_URGENT);
    repeat (3) add_entry(0, $urandom, mcpd_pkg::PRI_REGULAR);
    add_entry(0, $urandom, 3);
  endtask

  // Urgent entries come out newest first, ahead of regular ones in order
  task automatic test_priority_order();
    add_entry(31, 16'h1111, mcpd_pkg::PRI_REGULAR);
    add_entry(31, 16'h2222, mcpd_pkg::PRI_REGULAR);
    add_entry(31, 16'h3333, mcpd_pkg::PRI_URGENT);
    add_entry(31, 16'h4444, mcpd_pkg::PRI_URGENT);
    add_entry(31, 16'h5555, 2);
    add_entry(31, 16'h6666, 3);
    repeat (5) take_entry(31);
  endtask

  // Limit of zero refuses everything; a limit past the depth acts as the depth
  task automatic test_limit_extremes();
    set_queue_limit(0);
    add_entry(5, $urandom, mcpd_pkg::PRI_REGULAR);
    set_queue_limit(15);
    repeat (3) add_entry(0, $urandom, mcpd_pkg::PRI_URGENT);
    add_entry(0, $urandom, mcpd_pkg::PRI_REGULAR);
    set_queue_limit(1);
    add_entry(0, $urandom, mcpd_pkg::PRI_REGULAR);
    add_entry(7, $urandom, mcpd_pkg::PRI_URGENT);
    add_entry(7, $urandom, mcpd_pkg::PRI_REGULAR);
  endtask

  // Random traffic focused on a few channels so rings fill up and drain
  task automatic test_random_traffic(input int count, input int idle_pct);
    int              hot [3];
    int              add_pct;
    int              ch;
    int              p;
    mcpd_pkg::mode_e m;
    deque_req_t      req;
    foreach (hot[k]) hot[k] = $urandom_range(NCH - 1);
    add_pct = 50;
    for (int n = 0; n < count; n++) begin
      // bursts leaning toward adds or takes
      if (n % 20 == 0) add_pct = $urandom_range(1) ? 70 : 30;
      ch = ($urandom_range(99) < 80) ? hot[$urandom_range(2)] : $urandom_range(NCH - 1);
      if ($urandom_range(99) < 10) p = $urandom_range(3, 2);
      else p = $urandom_range(1) ? mcpd_pkg::PRI_URGENT : mcpd_pkg::PRI_REGULAR;
      m   = ($urandom_range(99) < add_pct) ? mcpd_pkg::MODE_ADD : mcpd_pkg::MODE_TAKE;
      req = make_req(m, ch, $urandom, p);
      hold_off(idle_pct);
      send_request(req);
    end
  endtask

  // Sequence of tests
  initial begin
    rst_ni           <= 1'b0;
    queue_limit_we_i <= 1'b0;
    queue_limit_i    <= '0;
    start_i          <= 1'b0;
    mode_i           <= 1'b0;
    channel_i        <= '0;
    entry_id_i       <= '0;
    priority_req_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_limit();
    test_priority_order();
    test_limit_extremes();

    set_queue_limit(15);
    test_random_traffic(410, 8);
    set_queue_limit(3);
    test_random_traffic(410, 68);
    set_queue_limit(8);
    test_random_traffic(410, 0);

    settle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("multi_channel_priority_deque regression: pass");
    end else begin
      $display("multi_channel_priority_deque regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("multi_channel_priority_deque regression: fail");
    $finish;
  end

endmodule

FILE: multi_channel_priority_deque.f
src/mcpd_pkg.sv
src/mcpd_ptr_table.sv
src/multi_channel_priority_deque.sv
test/testbench.sv
